// ----- hw/rtl/dvh_pkg.sv -----
// Shared types and constants for the distinct value histogram.
package dvh_pkg;

    localparam int OPCODE_WIDTH = 2;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

endpackage

// ----- hw/rtl/dvh_req_if.sv -----
// Request channel: opcode, sample and index words with valid/ready.
interface dvh_req_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX_WIDTH = 6
);
    import dvh_pkg::*;

    logic                          valid;
    logic                          ready;
    t_opcode                       opcode;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic [INDEX_WIDTH-1:0]        entry_index;

    modport source (output valid, output opcode, output sample_value, output entry_index,
                    input ready);
    modport sink   (input valid, input opcode, input sample_value, input entry_index,
                    output ready);
endinterface

// ----- hw/rtl/dvh_rsp_if.sv -----
// Response channel: entry value, count and status words with valid/ready.
interface dvh_rsp_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 32,
    parameter int INDEX_WIDTH = 6,
    parameter int USED_WIDTH  = 7
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] entry_value;
    logic [COUNT_WIDTH-1:0]        entry_count;
    logic [INDEX_WIDTH-1:0]        entry_slot;
    logic                          found_existing;
    logic                          table_full;
    logic                          slot_valid;
    logic [USED_WIDTH-1:0]         distinct_count;

    modport source (output valid, output entry_value, output entry_count, output entry_slot,
                    output found_existing, output table_full, output slot_valid,
                    output distinct_count, input ready);
    modport sink   (input valid, input entry_value, input entry_count, input entry_slot,
                    input found_existing, input table_full, input slot_valid,
                    input distinct_count, output ready);
endinterface

// ----- hw/rtl/distinct_value_histogram.sv -----
// Distinct value histogram: table of first-seen values with saturating counts.
//
// Requests arrive on i_req (valid/ready); each word carries an opcode: add a sample,
// read the entry at an index, or clear the table. Every request yields exactly one
// response word on o_rsp (valid/ready) with value, count, slot and status flags.
// Values and counts live in one RAM; an add walks the used entries one per cycle
// through a single comparator and incrementer, with reads pipelined ahead of the compare.
// An add searches the used entries until it finds a match or reaches the end of them;
// a read of an index in range reads the RAM first, while a read out of range, a clear
// and an unknown opcode go straight to the result state.
// One request is in work at a time; i_req.ready is high only while idle, so the
// request rate is set by the search length and by waits for the output register.
// The response sits in an output register: a new request is taken while an earlier
// response still waits, and a finished result is held until the register frees.
// Reset empties the table (distinct count 0) and drops any pending response;
// RAM contents are not cleared, since only entries below the count are ever used.
module distinct_value_histogram #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dvh_req_if.sink    i_req,
    dvh_rsp_if.source  o_rsp
);
    import dvh_pkg::*;

    localparam int INDEX_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_WIDTH  = INDEX_WIDTH + 1;
    localparam int MEM_WIDTH   = VALUE_WIDTH + COUNT_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [USED_WIDTH-1:0]         r_used, n_used;
    logic [USED_WIDTH-1:0]         r_scan, n_scan;
    logic                          r_chk, n_chk;
    logic [USED_WIDTH-1:0]         r_chk_idx, n_chk_idx;
    logic signed [VALUE_WIDTH-1:0] r_sample, n_sample;

    logic signed [VALUE_WIDTH-1:0] r_res_value, n_res_value;
    logic [COUNT_WIDTH-1:0]        r_res_count, n_res_count;
    logic [INDEX_WIDTH-1:0]        r_res_slot, n_res_slot;
    logic                          r_res_found, n_res_found;
    logic                          r_res_full, n_res_full;
    logic                          r_res_hit, n_res_hit;
    logic [USED_WIDTH-1:0]         r_res_distinct, n_res_distinct;

    logic                          r_o_valid, n_o_valid;
    logic signed [VALUE_WIDTH-1:0] r_o_value, n_o_value;
    logic [COUNT_WIDTH-1:0]        r_o_count, n_o_count;
    logic [INDEX_WIDTH-1:0]        r_o_slot, n_o_slot;
    logic                          r_o_found, n_o_found;
    logic                          r_o_full, n_o_full;
    logic                          r_o_hit, n_o_hit;
    logic [USED_WIDTH-1:0]         r_o_distinct, n_o_distinct;

    logic                          mem_we;
    logic [INDEX_WIDTH-1:0]        mem_waddr;
    logic [MEM_WIDTH-1:0]          mem_wdata;
    logic [INDEX_WIDTH-1:0]        mem_raddr;
    logic [MEM_WIDTH-1:0]          mem_rdata;

    logic                          req_accept;
    logic                          out_free;
    logic                          rd_in_range;
    logic                          scan_issue;
    logic                          scan_match;
    logic                          scan_miss;
    logic [VALUE_WIDTH-1:0]        rd_value;
    logic [COUNT_WIDTH-1:0]        rd_count;
    logic [COUNT_WIDTH-1:0]        sat_count;

    dvh_ram #(
        .WIDTH (MEM_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_accept  = i_req.valid && (r_state == ST_IDLE);
    assign out_free    = !r_o_valid || o_rsp.ready;
    assign rd_in_range = {1'b0, i_req.entry_index} < r_used;

    // shared compare and saturating increment over the entry read last cycle
    assign rd_value   = mem_rdata[MEM_WIDTH-1:COUNT_WIDTH];
    assign rd_count   = mem_rdata[COUNT_WIDTH-1:0];
    assign sat_count  = (&rd_count) ? rd_count : rd_count + COUNT_WIDTH'(1);
    assign scan_issue = r_scan < r_used;
    assign scan_match = r_chk && (rd_value == r_sample);
    assign scan_miss  = r_chk ? (r_chk_idx + USED_WIDTH'(1) == r_used) : (r_scan == r_used);

    always_comb begin
        n_state        = r_state;
        n_used         = r_used;
        n_scan         = r_scan;
        n_chk          = r_chk;
        n_chk_idx      = r_chk_idx;
        n_sample       = r_sample;
        n_res_value    = r_res_value;
        n_res_count    = r_res_count;
        n_res_slot     = r_res_slot;
        n_res_found    = r_res_found;
        n_res_full     = r_res_full;
        n_res_hit      = r_res_hit;
        n_res_distinct = r_res_distinct;
        n_o_valid      = r_o_valid;
        n_o_value      = r_o_value;
        n_o_count      = r_o_count;
        n_o_slot       = r_o_slot;
        n_o_found      = r_o_found;
        n_o_full       = r_o_full;
        n_o_hit        = r_o_hit;
        n_o_distinct   = r_o_distinct;
        mem_we         = 1'b0;
        mem_waddr      = r_used[INDEX_WIDTH-1:0];
        mem_wdata      = {r_sample, COUNT_WIDTH'(1)};
        mem_raddr      = r_scan[INDEX_WIDTH-1:0];

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                mem_raddr = i_req.entry_index;
                if (req_accept) begin
                    n_sample       = i_req.sample_value;
                    n_scan         = '0;
                    n_chk          = 1'b0;
                    n_res_value    = '0;
                    n_res_count    = '0;
                    n_res_slot     = '0;
                    n_res_found    = 1'b0;
                    n_res_full     = 1'b0;
                    n_res_hit      = 1'b0;
                    n_res_distinct = r_used;
                    unique case (i_req.opcode)
                        OP_ADD: begin
                            n_state = ST_SCAN;
                        end
                        OP_READ: begin
                            n_res_slot = i_req.entry_index;
                            n_state    = rd_in_range ? ST_READ : ST_DONE;
                        end
                        OP_CLEAR: begin
                            n_used         = '0;
                            n_res_distinct = '0;
                            n_state        = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next address while comparing the one read last cycle
                n_chk     = scan_issue;
                n_chk_idx = r_scan;
                if (scan_issue) begin
                    n_scan = r_scan + USED_WIDTH'(1);
                end
                if (scan_match) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_chk_idx[INDEX_WIDTH-1:0];
                    mem_wdata   = {rd_value, sat_count};
                    n_res_value = rd_value;
                    n_res_count = sat_count;
                    n_res_slot  = r_chk_idx[INDEX_WIDTH-1:0];
                    n_res_found = 1'b1;
                    n_chk       = 1'b0;
                    n_state     = ST_DONE;
                end else if (scan_miss) begin
                    n_chk = 1'b0;
                    if (r_used == USED_WIDTH'(TABLE_DEPTH)) begin
                        n_res_value = r_sample;
                        n_res_full  = 1'b1;
                    end else begin
                        mem_we         = 1'b1;
                        n_res_value    = r_sample;
                        n_res_count    = COUNT_WIDTH'(1);
                        n_res_slot     = r_used[INDEX_WIDTH-1:0];
                        n_used         = r_used + USED_WIDTH'(1);
                        n_res_distinct = r_used + USED_WIDTH'(1);
                    end
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_res_value = rd_value;
                n_res_count = rd_count;
                n_res_hit   = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_value    = r_res_value;
                    n_o_count    = r_res_count;
                    n_o_slot     = r_res_slot;
                    n_o_found    = r_res_found;
                    n_o_full     = r_res_full;
                    n_o_hit      = r_res_hit;
                    n_o_distinct = r_res_distinct;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_chk     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_chk     <= n_chk;
            r_o_valid <= n_o_valid;
        end
        r_scan         <= n_scan;
        r_chk_idx      <= n_chk_idx;
        r_sample       <= n_sample;
        r_res_value    <= n_res_value;
        r_res_count    <= n_res_count;
        r_res_slot     <= n_res_slot;
        r_res_found    <= n_res_found;
        r_res_full     <= n_res_full;
        r_res_hit      <= n_res_hit;
        r_res_distinct <= n_res_distinct;
        r_o_value      <= n_o_value;
        r_o_count      <= n_o_count;
        r_o_slot       <= n_o_slot;
        r_o_found      <= n_o_found;
        r_o_full       <= n_o_full;
        r_o_hit        <= n_o_hit;
        r_o_distinct   <= n_o_distinct;
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.entry_value    = r_o_value;
    assign o_rsp.entry_count    = r_o_count;
    assign o_rsp.entry_slot     = r_o_slot;
    assign o_rsp.found_existing = r_o_found;
    assign o_rsp.table_full     = r_o_full;
    assign o_rsp.slot_valid     = r_o_hit;
    assign o_rsp.distinct_count = r_o_distinct;

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_WIDTH'(TABLE_DEPTH))
        else $error("distinct count exceeds table depth");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_SCAN))
        else $error("table written outside a search");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_o_valid && r_state == ST_IDLE))
        else $error("finished result not moved to output register");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && i_req.opcode == OP_CLEAR) |=> (r_used == '0))
        else $error("clear did not empty the table");
endmodule

// ----- hw/rtl/dvh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dvh_ram #(
    parameter int  WIDTH      = 64,
    parameter int  DEPTH      = 64,
    localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_WIDTH-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [ADDR_WIDTH-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the distinct value histogram: add, read, clear, reserved-opcode and table-full traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dvh_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [OPCODE_WIDTH-1:0] OPC_RESERVED = 2'd3;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] count;
        logic [5:0]  slot;
        logic        found;
        logic        full;
        logic        in_range;
        logic [6:0]  distinct;
    } t_entry_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dvh_req_if #(.VALUE_WIDTH(32), .INDEX_WIDTH(6)) req_if();
    dvh_rsp_if #(.VALUE_WIDTH(32), .COUNT_WIDTH(32), .INDEX_WIDTH(6), .USED_WIDTH(7)) rsp_if();

    distinct_value_histogram #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_WIDTH(32),
        .COUNT_WIDTH(32)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the histogram table
    logic [31:0]   hist_values [TABLE_DEPTH];
    logic [31:0]   hist_counts [TABLE_DEPTH];
    int            hist_used = 0;
    t_entry_result expected_entries[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            idling_on = 1'b1;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("distinct_value_histogram: mismatch");
            $finish;
        end
    end

    // Response side: stall about one cycle in five while idling is on
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= !(idling_on && $urandom_range(99) < 20);
        end
    end

    function automatic t_entry_result histogram_step(logic [1:0] op, logic [31:0] sample,
                                                     logic [5:0] index);
        t_entry_result r;
        int            slot;
        r = '0;
        slot = -1;
        case (op)
            OP_ADD: begin
                for (int j = 0; j < hist_used; j++)
                    if (slot < 0 && hist_values[j] == sample) slot = j;
                if (slot >= 0) begin
                    if (hist_counts[slot] != COUNT_MAX) hist_counts[slot]++;
                    r.value = hist_values[slot];
                    r.count = hist_counts[slot];
                    r.slot  = slot[5:0];
                    r.found = 1'b1;
                end else if (hist_used < TABLE_DEPTH) begin
                    hist_values[hist_used] = sample;
                    hist_counts[hist_used] = 32'd1;
                    r.value = sample;
                    r.count = 32'd1;
                    r.slot  = hist_used[5:0];
                    hist_used++;
                end else begin
                    r.value = sample;
                    r.full  = 1'b1;
                end
            end
            OP_READ: begin
                r.slot = index;
                if (index < hist_used) begin
                    r.value    = hist_values[index];
                    r.count    = hist_counts[index];
                    r.in_range = 1'b1;
                end
            end
            OP_CLEAR: hist_used = 0;
            default: ;
        endcase
        r.distinct = hist_used[6:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_rsp
        t_entry_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected word, expected none got value %h slot %0d",
                         $time, rsp_if.entry_value, rsp_if.entry_slot);
                mismatch_count++;
            end else begin
                want = expected_entries.pop_front();
                check_field("entry_value", want.value, rsp_if.entry_value);
                check_field("entry_count", want.count, rsp_if.entry_count);
                check_field("entry_slot", 32'(want.slot), 32'(rsp_if.entry_slot));
                check_field("found_existing", 32'(want.found), 32'(rsp_if.found_existing));
                check_field("table_full", 32'(want.full), 32'(rsp_if.table_full));
                check_field("slot_valid", 32'(want.in_range), 32'(rsp_if.slot_valid));
                check_field("distinct_count", 32'(want.distinct), 32'(rsp_if.distinct_count));
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [1:0] op, input logic [31:0] sample,
                             input logic [5:0] index);
        while (idling_on && $urandom_range(99) < 20) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.opcode       <= t_opcode'(op);
        req_if.sample_value <= sample;
        req_if.entry_index  <= index;
        do @(posedge i_clk); while (!req_if.ready);
        expected_entries.push_back(histogram_step(op, sample, index));
        @(negedge i_clk);
    endtask

    task automatic test_directed_edges();
        send_word(OP_READ, 32'h0, 6'd0);            // empty table
        send_word(OP_ADD, 32'h0000_0000, 6'd63);
        send_word(OP_ADD, 32'h7FFF_FFFF, 6'd0);
        send_word(OP_ADD, 32'h8000_0000, 6'd0);
        send_word(OP_ADD, 32'hFFFF_FFFF, 6'd0);
        send_word(OP_ADD, 32'h0000_0000, 6'd0);     // match at the first slot
        send_word(OP_ADD, 32'hFFFF_FFFF, 6'd0);     // match at the last used slot
        send_word(OP_READ, 32'hFFFF_FFFF, 6'd0);
        send_word(OP_READ, 32'h0, 6'd3);
        send_word(OP_READ, 32'h0, 6'd4);            // first unused slot
        send_word(OP_READ, 32'h0, 6'd63);
        send_word(OPC_RESERVED, 32'hA5A5_5A5A, 6'd42);
        send_word(OP_CLEAR, 32'h1234_5678, 6'd21);
        send_word(OP_READ, 32'h0, 6'd0);            // old slot after clear
        send_word(OP_ADD, 32'h8000_0000, 6'd0);
        send_word(OP_ADD, 32'h8000_0000, 6'd0);
    endtask

    task automatic test_table_full();
        logic [31:0] sample;
        bit          seen;
        send_word(OP_CLEAR, $urandom, 6'($urandom));
        while (hist_used < TABLE_DEPTH) begin
            // draw until the value is new to the table
            do begin
                sample = $urandom;
                seen = 1'b0;
                for (int j = 0; j < hist_used; j++)
                    if (hist_values[j] == sample) seen = 1'b1;
            end while (seen);
            send_word(OP_ADD, sample, 6'($urandom));
        end
        send_word(OP_ADD, ~hist_values[0] ^ 32'h1, 6'($urandom));
        send_word(OP_ADD, hist_values[TABLE_DEPTH-1], 6'($urandom));
        send_word(OP_ADD, hist_values[0], 6'($urandom));
        send_word(OP_READ, $urandom, 6'd63);
        send_word(OP_READ, $urandom, 6'($urandom));
        send_word(OP_ADD, $urandom, 6'($urandom));
    endtask

    task automatic test_random_mix(input int words);
        int          pick;
        int          clear_pct;
        logic [31:0] sample;
        logic [31:0] corner_values [5];
        corner_values = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        for (int n = 0; n < words; n++) begin
            idling_on = !(n >= words / 3 && n < words / 3 + 150);
            // clear mostly once the table has filled up
            clear_pct = (hist_used == TABLE_DEPTH) ? 8 : 1;
            pick = $urandom_range(99);
            sample = $urandom;
            if (pick < 2) begin
                send_word(OPC_RESERVED, sample, 6'($urandom));
            end else if (pick < 2 + clear_pct) begin
                send_word(OP_CLEAR, sample, 6'($urandom));
            end else if (pick < 24 + clear_pct) begin
                if (hist_used != 0 && $urandom_range(3) != 0)
                    send_word(OP_READ, sample, 6'($urandom_range(hist_used - 1)));
                else
                    send_word(OP_READ, sample, 6'($urandom_range(63)));
            end else begin
                pick = $urandom_range(99);
                if (hist_used != 0 && pick < 55)
                    sample = hist_values[$urandom_range(hist_used - 1)];
                else if (pick < 65)
                    sample = corner_values[$urandom_range(4)];
                send_word(OP_ADD, sample, 6'($urandom));
            end
        end
        idling_on = 1'b1;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.opcode       = OP_ADD;
        req_if.sample_value = '0;
        req_if.entry_index  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_edges();
        test_table_full();
        test_random_mix(860);
        req_if.valid <= 1'b0;

        while (expected_entries.size() != 0) @(posedge i_clk);
        // catch any stray word after the last expected one
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("distinct_value_histogram: match");
        else
            $display("distinct_value_histogram: mismatch");
        $finish;
    end

endmodule
